// ----- rtl/core/todcc_pkg.sv -----
// ----------------------------------------------------------------------------
// todcc_pkg
// Shared types and codes for the time-of-day clock with countdown.
// ----------------------------------------------------------------------------
package todcc_pkg;

  // Countdown command codes
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_PAUSE  = 3'd2;
  localparam logic [2:0] CMD_RESUME = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;

  // Field moduli
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned MIN_PER_HR  = 60;
  localparam int unsigned HR_PER_DAY  = 24;

  // Calendar fields of the clock
  typedef struct packed {
    logic [31:0] total;
    logic [9:0]  ms;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [7:0]  day;
  } clock_t;

endpackage

// ----- rtl/core/time_of_day_clock_with_countdown.sv -----
// ----------------------------------------------------------------------------
// time_of_day_clock_with_countdown
// Item path: input register, then the state register that holds the result.
// Throughput: one item beat per cycle while the result is not stalled.
// Reset: all clock fields and the countdown clear to zero, countdown stopped.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_countdown (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  command,
  input  logic [15:0] elapsed_ms,
  input  logic [15:0] countdown_load,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] total_ms,
  output logic [9:0]  millis,
  output logic [5:0]  seconds,
  output logic [5:0]  minutes,
  output logic [4:0]  hours,
  output logic [7:0]  days,
  output logic        time_up,
  output logic        countdown_running,
  output logic [15:0] countdown_left
);

  // Input register: one item beat waiting for the update
  logic        in_valid;
  logic [2:0]  in_cmd;
  logic [15:0] in_dt;
  logic [15:0] in_load;

  // Architectural state; it doubles as the result register, since it only
  // changes when a result beat is produced.
  todcc_pkg::clock_t clock;
  todcc_pkg::clock_t clock_next;
  logic              running;
  logic              running_next;
  logic [15:0]       remaining;
  logic [15:0]       remaining_next;

  logic out_free;
  logic fire;

  // Result slot is free when empty or being drained this cycle
  assign out_free   = !result_valid || !result_stall;
  assign fire       = in_valid && out_free;
  // Hold the input only when its item cannot move forward
  assign item_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_cmd  <= command;
      in_dt   <= elapsed_ms;
      in_load <= countdown_load;
    end
  end

  // Clock cascade: a zero elapsed count leaves every field as is
  todcc_cascade u_cascade (
    .cur (clock),
    .dt  (in_dt),
    .nxt (clock_next)
  );

  // Countdown: first drop the elapsed time, then apply the command
  always_comb begin
    running_next   = running;
    remaining_next = remaining;
    if (running && (in_dt != 16'd0)) begin
      if (remaining > in_dt) begin
        remaining_next = remaining - in_dt;
      end else begin
        // expired: stop at zero
        remaining_next = 16'd0;
        running_next   = 1'b0;
      end
    end
    case (in_cmd)
      todcc_pkg::CMD_START: begin
        remaining_next = in_load;
        running_next   = 1'b1;
      end
      todcc_pkg::CMD_PAUSE: begin
        running_next = 1'b0;
      end
      todcc_pkg::CMD_RESUME: begin
        running_next = 1'b1;
      end
      todcc_pkg::CMD_CANCEL: begin
        remaining_next = 16'd0;
        running_next   = 1'b0;
      end
      default: begin
        // none, and unused codes: keep countdown as advanced
      end
    endcase
  end

  // Commit the state and present it as the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      clock        <= '0;
      running      <= 1'b0;
      remaining    <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        clock     <= clock_next;
        running   <= running_next;
        remaining <= remaining_next;
      end
      if (out_free) begin
        result_valid <= in_valid;
      end
    end
  end

  assign total_ms          = clock.total;
  assign millis            = clock.ms;
  assign seconds           = clock.sec;
  assign minutes           = clock.min;
  assign hours             = clock.hour;
  assign days              = clock.day;
  assign time_up           = (remaining == 16'd0);
  assign countdown_running = running;
  assign countdown_left    = remaining;

endmodule

// ----- rtl/core/todcc_cascade.sv -----
// ----------------------------------------------------------------------------
// todcc_cascade
// Advances the clock fields by an elapsed millisecond count, one carry chain.
// ----------------------------------------------------------------------------
module todcc_cascade (
  input  todcc_pkg::clock_t cur,
  input  logic [15:0]       dt,
  output todcc_pkg::clock_t nxt
);

  // Reciprocal of 1000 scaled by 2^26, exact for sums below 2^17
  localparam logic [33:0] RECIP_MS = 34'd67109;
  localparam int unsigned RECIP_SH = 26;

  logic [16:0] ms_acc;
  logic [33:0] ms_prod;
  logic [6:0]  ms_carry;
  logic [16:0] ms_carry_x;
  logic [16:0] ms_used;
  logic [16:0] ms_rem;
  logic [6:0]  sec_acc;
  logic [1:0]  sec_carry;
  logic [6:0]  sec_rem;
  logic [6:0]  min_acc;
  logic        min_carry;
  logic [6:0]  min_rem;
  logic [4:0]  hr_acc;
  logic        hr_carry;
  logic [4:0]  hr_rem;

  // Milliseconds: quotient by reciprocal multiply, remainder by shift-subtract
  assign ms_acc     = {7'd0, cur.ms} + {1'b0, dt};
  assign ms_prod    = {17'd0, ms_acc} * RECIP_MS;
  assign ms_carry   = ms_prod[RECIP_SH+6:RECIP_SH];
  assign ms_carry_x = {10'd0, ms_carry};
  assign ms_used    = (ms_carry_x << 10) - (ms_carry_x << 4) - (ms_carry_x << 3);
  assign ms_rem     = ms_acc - ms_used;

  // Seconds: sum stays below 2*60+6, so at most two subtracts
  assign sec_acc = ms_carry + {1'b0, cur.sec};
  always_comb begin
    if (sec_acc >= 7'(2 * todcc_pkg::SEC_PER_MIN)) begin
      sec_carry = 2'd2;
      sec_rem   = sec_acc - 7'(2 * todcc_pkg::SEC_PER_MIN);
    end else if (sec_acc >= 7'(todcc_pkg::SEC_PER_MIN)) begin
      sec_carry = 2'd1;
      sec_rem   = sec_acc - 7'(todcc_pkg::SEC_PER_MIN);
    end else begin
      sec_carry = 2'd0;
      sec_rem   = sec_acc;
    end
  end

  // Minutes
  assign min_acc   = {5'd0, sec_carry} + {1'b0, cur.min};
  assign min_carry = (min_acc >= 7'(todcc_pkg::MIN_PER_HR));
  assign min_rem   = min_carry ? (min_acc - 7'(todcc_pkg::MIN_PER_HR)) : min_acc;

  // Hours
  assign hr_acc   = {4'd0, min_carry} + cur.hour;
  assign hr_carry = (hr_acc >= 5'(todcc_pkg::HR_PER_DAY));
  assign hr_rem   = hr_carry ? (hr_acc - 5'(todcc_pkg::HR_PER_DAY)) : hr_acc;

  assign nxt.total = cur.total + {16'd0, dt};
  assign nxt.ms    = ms_rem[9:0];
  assign nxt.sec   = sec_rem[5:0];
  assign nxt.min   = min_rem[5:0];
  assign nxt.hour  = hr_rem;
  assign nxt.day   = cur.day + {7'd0, hr_carry};

endmodule
